@@ rtl/core/crkh_pkg.sv @@
// Package with the types, constants and helper functions of the challenge response key hash.
package crkh_pkg;

  localparam logic [30:0] ModP   = 31'h7FFF_FFFF;
  localparam logic [30:0] MagicK = 31'h0E79_A9C1;
  localparam int unsigned ResW   = 31;

  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_low;
    logic [30:0] word_a;
    logic [30:0] word_b;
    logic        last_chunk;
  } in_item_t;

  typedef struct packed {
    logic [63:0] response_upper;
    logic [63:0] response_lower;
  } out_item_t;

  // Request to the serial modular multiplier: result = (x * y + c) mod (2^31 - 1).
  typedef struct packed {
    logic        start;
    logic [30:0] x;
    logic [30:0] y;
    logic [30:0] c;
  } mm_req_t;

  function automatic logic [31:0] swap32(input logic [31:0] w);
    swap32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [30:0] mult_of(input logic [31:0] w);
    logic [31:0] s;
    s = swap32(w);
    mult_of = s[30:0];
  endfunction

  // Reduces a value below 2^33 modulo 2^31 - 1 by folding the upper bits.
  function automatic logic [30:0] red33(input logic [32:0] v);
    logic [31:0] s;
    logic [31:0] f;
    s = {1'b0, v[30:0]} + {30'd0, v[32:31]};
    f = {1'b0, s[30:0]} + {31'd0, s[31]};
    red33 = (f[30:0] == ModP) ? 31'd0 : f[30:0];
  endfunction

  function automatic logic [30:0] red31(input logic [30:0] v);
    red31 = (v == ModP) ? 31'd0 : v;
  endfunction

endpackage

@@ rtl/core/crkh_mulmod.sv @@
// Bit-serial multiply-add modulo 2^31 - 1, one multiplier bit per cycle.
module crkh_mulmod (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  crkh_pkg::mm_req_t req_i,
  output logic            done_o,
  output logic [30:0]     res_o
);
  import crkh_pkg::*;

  logic [30:0] acc_q, acc_d, x_q, y_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] step;

  // Seeding the accumulator with c works because 2^31 is congruent to 1.
  assign step  = {1'b0, acc_q, 1'b0} + (y_q[30] ? {2'b00, x_q} : 33'd0);
  assign acc_d = red33(step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(ResW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= req_i.c;
      x_q   <= req_i.x;
      y_q   <= req_i.y;
    end else if (busy_q) begin
      acc_q <= acc_d;
      y_q   <= {y_q[29:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;
endmodule

@@ rtl/core/challenge_response_key_hash.sv @@
// Top level of the challenge response key hash.
// This block takes one chunk of the padded challenge string, as two 31-bit words, per
// transaction together with the two digest halves, and advances a chained multiply-add modulo
// 2^31 - 1. A chunk occupies the block from its acceptance until the next chunk can be
// accepted: three modular products in a single shared bit-serial unit, each a load followed
// by the serial work of the multiplier bits, and then a return to idle. One chunk is in work
// at a time. On the chunk marked last, the chain is reduced to a 64-bit key in the StFin state.
// One result transaction carrying both digest halves XORed with that key is then offered, and
// the chain state is cleared. A finished result waits in its own register, so the next chunk
// may be taken while it is still unclaimed. A last chunk is held in StFin for as long as the
// previous result remains unclaimed.
module challenge_response_key_hash (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  crkh_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output crkh_pkg::out_item_t out_data_o
);
  import crkh_pkg::*;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul1 = 5'b00010,
    StMul2 = 5'b00100,
    StMul3 = 5'b01000,
    StFin  = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  in_item_t    item_q;
  logic [30:0] high_q, t_q;
  logic [63:0] low_q;
  logic        out_valid_q;
  out_item_t   out_q;
  mm_req_t     req;
  logic        mm_done;
  logic [30:0] mm_res;

  logic [30:0] m0, m1, m2, m3;
  logic [31:0] t_sum;
  logic [30:0] fh, fl, low_red;
  logic [32:0] low_fold;
  logic [63:0] key;
  logic        accept;

  assign m0 = mult_of(item_q.digest_high[63:32]);
  assign m1 = mult_of(item_q.digest_high[31:0]);
  assign m2 = mult_of(item_q.digest_low[63:32]);
  assign m3 = mult_of(item_q.digest_low[31:0]);

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);

  // The first product plus the previous high value, before its reduction.
  assign t_sum = {1'b0, mm_res} + {1'b0, high_q};

  // The low sum is folded in 31-bit pieces, since 2^31 is congruent to 1.
  assign low_fold = {2'b00, low_q[30:0]} + {2'b00, low_q[61:31]} + {31'd0, low_q[63:62]};
  assign low_red  = red33(low_fold);
  assign fh       = red33({2'b00, high_q} + {2'b00, m1});
  assign fl       = red33({2'b00, low_red} + {2'b00, m3});
  assign key      = {swap32({1'b0, fh}), swap32({1'b0, fl})};

  // A multiplier run is requested as the prior step ends and loads as its state is entered.
  always_comb begin
    req = '0;
    if (accept) begin
      req.start = 1'b1;
      req.x     = red31(in_data_i.word_a);
      req.y     = MagicK;
    end else if (state_q == StMul1 && mm_done) begin
      req.start = 1'b1;
      req.x     = red33({1'b0, t_sum});
      req.y     = m0;
      req.c     = red31(m1);
    end else if (state_q == StMul2 && mm_done) begin
      req.start = 1'b1;
      req.x     = red33({2'b00, item_q.word_b} + {2'b00, mm_res});
      req.y     = m2;
      req.c     = red31(m3);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept) state_d = StMul1;
      StMul1: if (mm_done) state_d = StMul2;
      StMul2: if (mm_done) state_d = StMul3;
      StMul3: if (mm_done) state_d = item_q.last_chunk ? StFin : StIdle;
      StFin:  if (!out_valid_q || out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      high_q      <= '0;
      low_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StMul3 && mm_done) begin
        high_q <= mm_res;
        low_q  <= low_q + {33'd0, mm_res} + {33'd0, t_q};
      end
      // A new result replaces one that is claimed in the same cycle.
      if (state_q == StFin && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
        high_q      <= '0;
        low_q       <= '0;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    if (state_q == StMul2 && mm_done) t_q <= mm_res;
    if (state_q == StFin && (!out_valid_q || out_ready_i)) begin
      out_q.response_upper <= item_q.digest_high ^ key;
      out_q.response_lower <= item_q.digest_low ^ key;
    end
  end

  crkh_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule
